[design/spn_pkg.sv]
package spn_pkg;

  // Field widths of the channels
  localparam int COORD_W = 24;
  localparam int OUT_W   = 18;

  // Permutation table geometry
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // Default number of fraction bits in the coordinates
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Shuffle generator
  localparam logic [31:0] SEED_RESET = 32'h0051_a007;
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;

  // Output saturation limits
  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Register port
  localparam int  APB_AW   = 3;
  localparam int  APB_DW   = 32;
  localparam logic REG_SEED = 1'b0;

endpackage

[design/spn_in_if.sv]
interface spn_in_if import spn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

[design/spn_out_if.sv]
interface spn_out_if import spn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

[design/seeded_perlin_noise_2d.sv]
// Seeded 2D gradient noise. One point (x_coord, y_coord, unsigned Q8.16 by default) enters per
// beat and one signed Q2.16 noise_value leaves per beat, in order. A thirteen-stage pipeline
// takes a new point in every cycle unless held by a stalled output or a table build; the fade and
// interpolation multipliers each sit in a stage of their own, and the three copies of the
// permutation table give the six table reads a point needs in one pass. A stalled output
// backs up the pipeline stage by stage, so bubbles are squeezed out before the input is held.
// After reset and after every write of the seed register the table is rebuilt: an identity
// fill, then 255 shuffle steps (generator update, remainder unit taking four bits a cycle over
// the whole generator word, one read, two writes through the single write port), during which
// no point is taken. The seed reads back over the register port at address 0.
module seeded_perlin_noise_2d import spn_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  spn_in_if.sink            coord_i,
  spn_out_if.source         noise_o
);

  localparam int F    = FRAC_BITS;
  localparam int ONE  = 1 << F;
  localparam int HALF = 1 << (F - 1);
  localparam int NS   = 13;

  // Datapath widths
  localparam int W_A1 = F + 5;
  localparam int W_P1 = 2 * F + 6;
  localparam int W_SQ = 2 * F;
  localparam int W_C  = F + 4;
  localparam int W_P3 = 2 * F + 1;
  localparam int W_P5 = 2 * F + 5;
  localparam int W_U  = F + 2;
  localparam int W_G  = F + 2;
  localparam int W_D  = F + 3;
  localparam int W_M  = 2 * F + 6;
  localparam int W_R  = F + 3;
  localparam int W_DR = F + 4;
  localparam int W_MR = 2 * F + 7;
  localparam int W_N  = F + 4;
  localparam int XE_W = COORD_W + IDX_W;
  localparam int W_S  = 48;

  // Output rescale to sixteen fraction bits
  localparam int SH_R = (F > 16) ? F - 16 : 0;
  localparam int SH_L = (F < 16) ? 16 - F : 0;
  localparam logic signed [W_S-1:0] RND_HALF =
    (SH_R > 0) ? (W_S'(1) <<< ((SH_R > 0) ? SH_R - 1 : 0)) : W_S'(0);

  // Corner order of the gradient lanes
  localparam int G_AA = 0;
  localparam int G_BA = 1;
  localparam int G_AB = 2;
  localparam int G_BB = 3;

  // Gradient directions
  localparam logic [2:0] GRAD_XPY = 3'd0;
  localparam logic [2:0] GRAD_NXPY = 3'd1;
  localparam logic [2:0] GRAD_XNY = 3'd2;
  localparam logic [2:0] GRAD_NXNY = 3'd3;
  localparam logic [2:0] GRAD_X = 3'd4;
  localparam logic [2:0] GRAD_NX = 3'd5;
  localparam logic [2:0] GRAD_Y = 3'd6;
  localparam logic [2:0] GRAD_NY = 3'd7;

  // Table builder states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_LCG  = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_WR_I = 3'd5;
  localparam logic [2:0] ST_WR_J = 3'd6;

  function automatic logic signed [W_G-1:0] grad(input logic [IDX_W-1:0] h,
                                                 input logic signed [F:0] gx,
                                                 input logic signed [F:0] gy);
    logic signed [W_G-1:0] ex;
    logic signed [W_G-1:0] ey;
    ex = W_G'(gx);
    ey = W_G'(gy);
    case (h[2:0])
      GRAD_XPY:  grad = ex + ey;
      GRAD_NXPY: grad = ey - ex;
      GRAD_XNY:  grad = ex - ey;
      GRAD_NXNY: grad = -ex - ey;
      GRAD_X:    grad = ex;
      GRAD_NX:   grad = -ex;
      GRAD_Y:    grad = ey;
      GRAD_NY:   grad = -ey;
      default:   grad = '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Register port and table builder
  // ---------------------------------------------------------------------------------------
  logic              cfg_wr;
  logic [31:0]       seed_q;
  logic [2:0]        state_q;
  logic [2:0]        state_d;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  idx_d;
  logic [31:0]       s_q;
  logic [31:0]       s_d;
  logic [IDX_W-1:0]  rem_q;
  logic [IDX_W-1:0]  rem_d;
  logic [2:0]        cnt_q;
  logic [2:0]        cnt_d;
  logic              busy;
  logic [IDX_W-1:0]  rem_step;
  logic [3:0]        nib;
  logic [IDX_W:0]    divisor;
  logic [IDX_W:0]    trial;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  wr_data;

  logic [IDX_W-1:0]  pa_q;
  logic [IDX_W-1:0]  pb_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_SEED);
  assign prdata = (paddr[APB_AW-1] == REG_SEED) ? seed_q : '0;
  assign busy   = (state_q != ST_IDLE);

  // Remainder of the generator word by i+1, four bits a cycle
  always_comb begin
    rem_step = rem_q;
    nib      = s_q[{~cnt_q, 2'b00} +: 4];
    divisor  = {1'b0, idx_q} + (IDX_W + 1)'(1);
    trial    = '0;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_step, nib[3-k]};
      if (trial >= divisor) begin
        trial = trial - divisor;
      end
      rem_step = trial[IDX_W-1:0];
    end
  end

  // Sequence fill and shuffle
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    s_d     = s_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = idx_q;
    case (state_q)
      ST_IDLE: begin
      end
      ST_FILL: begin
        wr_en = 1'b1;
        if (idx_q == IDX_W'(TABLE_SIZE - 1)) begin
          state_d = ST_LCG;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_LCG: begin
        s_d     = 32'(s_q * LCG_MUL + LCG_ADD);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        rem_d = rem_step;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WR_I;
      end
      ST_WR_I: begin
        wr_en   = 1'b1;
        wr_data = pb_q;
        state_d = ST_WR_J;
      end
      ST_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = rem_q;
        wr_data = pa_q;
        if (idx_q == IDX_W'(1)) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q - IDX_W'(1);
          state_d = ST_LCG;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold seed and builder state; a seed write restarts the build
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= SEED_RESET;
      state_q <= ST_FILL;
      idx_q   <= '0;
      s_q     <= SEED_RESET;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (cfg_wr) begin
      seed_q  <= pwdata;
      state_q <= ST_FILL;
      idx_q   <= '0;
      s_q     <= (pwdata == '0) ? 32'd1 : pwdata;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      s_q     <= s_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control: each stage loads when it is empty or the stage after it moves
  // ---------------------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS-1:0] ld;
  logic          acc;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      ld[k] = noise_o.ready || !(&(v_q | ((NS'(1) << k) - NS'(1))));
    end
  end

  assign coord_i.ready = ld[0] && !busy && !cfg_wr;
  assign acc           = coord_i.valid && coord_i.ready;

  always_comb begin
    v_d[0] = ld[0] ? acc : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = ld[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Permutation table, three copies written alike
  // ---------------------------------------------------------------------------------------
  logic [IDX_W-1:0] tbl_a [TABLE_SIZE];
  logic [IDX_W-1:0] tbl_b [TABLE_SIZE];
  logic [IDX_W-1:0] tbl_c [TABLE_SIZE];

  logic [XE_W-1:0]  x_ext;
  logic [XE_W-1:0]  y_ext;
  logic [IDX_W-1:0] xi_in;
  logic [IDX_W-1:0] rda0;
  logic [IDX_W-1:0] rda1;
  logic             rda_en;
  logic [IDX_W-1:0] rdb0;
  logic [IDX_W-1:0] rdb1;
  logic [IDX_W-1:0] rdc0;
  logic [IDX_W-1:0] rdc1;

  logic [IDX_W-1:0] yi0_q;
  logic [IDX_W-1:0] h_aa_q;
  logic [IDX_W-1:0] h_ab_q;
  logic [IDX_W-1:0] h_ba_q;
  logic [IDX_W-1:0] h_bb_q;

  assign x_ext  = {{IDX_W{1'b0}}, coord_i.x_coord};
  assign y_ext  = {{IDX_W{1'b0}}, coord_i.y_coord};
  assign xi_in  = x_ext[F +: IDX_W];
  assign rda0   = busy ? idx_q : xi_in;
  assign rda1   = busy ? rem_q : xi_in + IDX_W'(1);
  assign rda_en = busy ? (state_q == ST_READ) : ld[0];
  assign rdb0   = pa_q + yi0_q;
  assign rdb1   = rdb0 + IDX_W'(1);
  assign rdc0   = pb_q + yi0_q;
  assign rdc1   = rdc0 + IDX_W'(1);

  // Write all copies; read the first copy for the cell column and the builder
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_a[wr_addr] <= wr_data;
      tbl_b[wr_addr] <= wr_data;
      tbl_c[wr_addr] <= wr_data;
    end
    if (rda_en) begin
      pa_q <= tbl_a[rda0];
      pb_q <= tbl_a[rda1];
    end
    if (ld[1]) begin
      h_aa_q <= tbl_b[rdb0];
      h_ab_q <= tbl_b[rdb1];
      h_ba_q <= tbl_c[rdc0];
      h_bb_q <= tbl_c[rdc1];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------------------
  logic        [F-1:0]     f0_d [2];
  logic        [F-1:0]     f0_q [2];
  logic        [IDX_W-1:0] yi0_d;

  logic signed [F:0]       ts1 [2];
  logic signed [W_A1-1:0]  a1 [2];
  logic signed [W_P1-1:0]  p1_d [2];
  logic signed [W_P1-1:0]  p1_q [2];
  logic        [W_SQ-1:0]  sq_d [2];
  logic        [W_SQ-1:0]  sq_q [2];
  logic        [F-1:0]     f1_q [2];

  logic signed [W_P1-1:0]  csum [2];
  logic        [W_SQ-1:0]  tsum [2];
  logic signed [F:0]       o_lo [2];
  logic signed [F:0]       o_hi [2];
  logic        [W_C-1:0]   c2_d [2];
  logic        [W_C-1:0]   c2_q [2];
  logic        [F:0]       t2_d [2];
  logic        [F:0]       t2_q [2];
  logic        [F-1:0]     f2_q [2];
  logic signed [W_G-1:0]   g2_d [4];
  logic signed [W_G-1:0]   g2_q [4];

  logic        [W_P3-1:0]  p3_d [2];
  logic        [W_P3-1:0]  p3_q [2];
  logic        [W_C-1:0]   c3_q [2];
  logic signed [W_G-1:0]   g3_q [4];

  logic        [W_P3-1:0]  t3sum [2];
  logic        [F:0]       t3_d [2];
  logic        [F:0]       t3_q [2];
  logic        [W_C-1:0]   c4_q [2];
  logic signed [W_D-1:0]   d4_d [2];
  logic signed [W_D-1:0]   d4_q [2];
  logic signed [W_G-1:0]   ga4_q [2];

  logic        [W_P5-1:0]  p5_d [2];
  logic        [W_P5-1:0]  p5_q [2];
  logic signed [W_D-1:0]   d5_q [2];
  logic signed [W_G-1:0]   ga5_q [2];

  logic        [W_P5-1:0]  usum [2];
  logic        [W_U-1:0]   fd6_d [2];
  logic        [W_U-1:0]   fd6_q [2];
  logic signed [W_D-1:0]   d6_q [2];
  logic signed [W_G-1:0]   ga6_q [2];

  logic signed [W_M-1:0]   m7_d [2];
  logic signed [W_M-1:0]   m7_q [2];
  logic signed [W_G-1:0]   ga7_q [2];
  logic        [W_U-1:0]   v7_q;

  logic signed [W_M-1:0]   rsum8 [2];
  logic signed [W_R-1:0]   row8_d [2];
  logic signed [W_R-1:0]   row8_q [2];
  logic        [W_U-1:0]   v8_q;

  logic signed [W_DR-1:0]  dr9_d;
  logic signed [W_DR-1:0]  dr9_q;
  logic signed [W_R-1:0]   row9_q;
  logic        [W_U-1:0]   v9_q;

  logic signed [W_MR-1:0]  mr10_d;
  logic signed [W_MR-1:0]  mr10_q;
  logic signed [W_R-1:0]   row10_q;

  logic signed [W_MR-1:0]  nsum;
  logic signed [W_N-1:0]   n11_d;
  logic signed [W_N-1:0]   n11_q;

  logic signed [W_S-1:0]   n48;
  logic signed [W_S-1:0]   scaled;
  logic signed [OUT_W-1:0] out12_d;
  logic signed [OUT_W-1:0] out12_q;

  always_comb begin
    // Stage 0: split coordinates into cell and fraction
    f0_d[0] = coord_i.x_coord[F-1:0];
    f0_d[1] = coord_i.y_coord[F-1:0];
    yi0_d   = y_ext[F +: IDX_W];

    for (int a = 0; a < 2; a++) begin
      // Stage 1: fade products t*(6t - 15) and t*t
      ts1[a]  = $signed({1'b0, f0_q[a]});
      a1[a]   = (W_A1'(ts1[a]) <<< 2) + (W_A1'(ts1[a]) <<< 1) - W_A1'(15 * ONE);
      p1_d[a] = W_P1'(ts1[a]) * W_P1'(a1[a]);
      sq_d[a] = W_SQ'(f0_q[a]) * W_SQ'(f0_q[a]);

      // Stage 2: round to c and t^2; corner offsets
      csum[a] = ((p1_q[a] + W_P1'(HALF)) >>> F) + W_P1'(10 * ONE);
      c2_d[a] = csum[a][W_C-1:0];
      tsum[a] = (sq_q[a] + W_SQ'(HALF)) >> F;
      t2_d[a] = tsum[a][F:0];
      o_lo[a] = $signed({1'b0, f1_q[a]});
      o_hi[a] = $signed({1'b1, f1_q[a]});

      // Stage 3: t^3 product
      p3_d[a] = W_P3'(t2_q[a]) * W_P3'(f2_q[a]);

      // Stage 4: round t^3
      t3sum[a] = (p3_q[a] + W_P3'(HALF)) >> F;
      t3_d[a]  = t3sum[a][F:0];

      // Stage 5: fade product t^3 * c
      p5_d[a] = W_P5'(t3_q[a]) * W_P5'(c4_q[a]);

      // Stage 6: round fade weight
      usum[a]  = (p5_q[a] + W_P5'(HALF)) >> F;
      fd6_d[a] = usum[a][W_U-1:0];
    end

    // Stage 2: gradients at the four corners
    g2_d[G_AA] = grad(h_aa_q, o_lo[0], o_lo[1]);
    g2_d[G_BA] = grad(h_ba_q, o_hi[0], o_lo[1]);
    g2_d[G_AB] = grad(h_ab_q, o_lo[0], o_hi[1]);
    g2_d[G_BB] = grad(h_bb_q, o_hi[0], o_hi[1]);

    // Stage 4: row differences
    d4_d[0] = W_D'(g3_q[G_BA]) - W_D'(g3_q[G_AA]);
    d4_d[1] = W_D'(g3_q[G_BB]) - W_D'(g3_q[G_AB]);

    for (int r = 0; r < 2; r++) begin
      // Stage 7: weight the row differences by u
      m7_d[r] = W_M'(d6_q[r]) * W_M'($signed({1'b0, fd6_q[0]}));

      // Stage 8: finish the rows
      rsum8[r]  = W_M'(ga7_q[r]) + ((m7_q[r] + W_M'(HALF)) >>> F);
      row8_d[r] = rsum8[r][W_R-1:0];
    end

    // Stage 9: column difference
    dr9_d = W_DR'(row8_q[1]) - W_DR'(row8_q[0]);

    // Stage 10: weight by v
    mr10_d = W_MR'(dr9_q) * W_MR'($signed({1'b0, v9_q}));

    // Stage 11: blend
    nsum  = W_MR'(row10_q) + ((mr10_q + W_MR'(HALF)) >>> F);
    n11_d = nsum[W_N-1:0];

    // Stage 12: rescale to sixteen fraction bits and saturate
    n48    = W_S'(n11_q);
    scaled = (SH_R > 0) ? ((n48 + RND_HALF) >>> SH_R) : (n48 <<< SH_L);
    if (scaled > W_S'(OUT_MAX)) begin
      out12_d = OUT_W'(OUT_MAX);
    end else if (scaled < W_S'(OUT_MIN)) begin
      out12_d = OUT_W'(OUT_MIN);
    end else begin
      out12_d = scaled[OUT_W-1:0];
    end
  end

  // Advance payload with its stage
  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      f0_q  <= f0_d;
      yi0_q <= yi0_d;
    end
    if (ld[1]) begin
      p1_q <= p1_d;
      sq_q <= sq_d;
      f1_q <= f0_q;
    end
    if (ld[2]) begin
      c2_q <= c2_d;
      t2_q <= t2_d;
      f2_q <= f1_q;
      g2_q <= g2_d;
    end
    if (ld[3]) begin
      p3_q <= p3_d;
      c3_q <= c2_q;
      g3_q <= g2_q;
    end
    if (ld[4]) begin
      t3_q     <= t3_d;
      c4_q     <= c3_q;
      d4_q     <= d4_d;
      ga4_q[0] <= g3_q[G_AA];
      ga4_q[1] <= g3_q[G_AB];
    end
    if (ld[5]) begin
      p5_q  <= p5_d;
      d5_q  <= d4_q;
      ga5_q <= ga4_q;
    end
    if (ld[6]) begin
      fd6_q <= fd6_d;
      d6_q  <= d5_q;
      ga6_q <= ga5_q;
    end
    if (ld[7]) begin
      m7_q  <= m7_d;
      ga7_q <= ga6_q;
      v7_q  <= fd6_q[1];
    end
    if (ld[8]) begin
      row8_q <= row8_d;
      v8_q   <= v7_q;
    end
    if (ld[9]) begin
      dr9_q  <= dr9_d;
      row9_q <= row8_q[0];
      v9_q   <= v8_q;
    end
    if (ld[10]) begin
      mr10_q  <= mr10_d;
      row10_q <= row9_q;
    end
    if (ld[11]) begin
      n11_q <= n11_d;
    end
    if (ld[12]) begin
      out12_q <= out12_d;
    end
  end

  assign noise_o.valid       = v_q[NS-1];
  assign noise_o.noise_value = out12_q;

endmodule
